// ===== src/adjacency_matrix_dfs_order_unit_defines.svh =====
// assertion macros for the dfs order unit
`ifndef ADJACENCY_MATRIX_DFS_ORDER_UNIT_DEFINES_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define AMDFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AMDFS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AMDFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define AMDFS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== src/amdfs_pkg.sv =====
// shared types and constants for the dfs order unit
package amdfs_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VW               = 6;
  localparam int VCNT_W           = 7;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 8;

  localparam logic FUNC_EDGE  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic idle;
    logic stack_empty;
  } amdfs_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EA_WR,
    S_EB_WR,
    S_SCAN,
    S_PICK,
    S_POPRD,
    S_FLUSH
  } amdfs_state_t;

endpackage

// ===== src/amdfs_adj_mem.sv =====
// adjacency row memory with per-row valid bits cleared at reset
module amdfs_adj_mem #(
  parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  amdfs_pkg::mem_ctl_t               ctl,
  input  logic [$clog2(MAX_VERTICES)-1:0]   waddr,
  input  logic [MAX_VERTICES-1:0]           wdata,
  input  logic [$clog2(MAX_VERTICES)-1:0]   raddr,
  output logic [MAX_VERTICES-1:0]           rdata
);
  import amdfs_pkg::*;

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_r;
  logic [MAX_VERTICES-1:0] rdata_r;
  logic                    rvalid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rvalid_r <= row_valid_r[raddr];
      end
      if (ctl.wr_en) begin
        row_valid_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

// ===== src/amdfs_stack_mem.sv =====
// path stack memory, one vertex per entry
module amdfs_stack_mem #(
  parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  amdfs_pkg::mem_ctl_t               ctl,
  input  logic [$clog2(MAX_VERTICES)-1:0]   waddr,
  input  logic [$clog2(MAX_VERTICES)-1:0]   wdata,
  input  logic [$clog2(MAX_VERTICES)-1:0]   raddr,
  output logic [$clog2(MAX_VERTICES)-1:0]   rdata
);
  import amdfs_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);

  logic [VIDX_W-1:0] mem [MAX_VERTICES];
  logic [VIDX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/amdfs_ctrl.sv =====
// edge loader and depth-first walk sequencer with output register
module amdfs_ctrl #(
  parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [amdfs_pkg::VCNT_W-1:0]          n_eff,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [amdfs_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [amdfs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                  out_tlast,
  output amdfs_pkg::mem_ctl_t                   adj_ctl,
  output logic [$clog2(MAX_VERTICES)-1:0]       adj_waddr,
  output logic [MAX_VERTICES-1:0]               adj_wdata,
  output logic [$clog2(MAX_VERTICES)-1:0]       adj_raddr,
  input  logic [MAX_VERTICES-1:0]               adj_rdata,
  output amdfs_pkg::mem_ctl_t                   stk_ctl,
  output logic [$clog2(MAX_VERTICES)-1:0]       stk_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0]       stk_wdata,
  output logic [$clog2(MAX_VERTICES)-1:0]       stk_raddr,
  input  logic [$clog2(MAX_VERTICES)-1:0]       stk_rdata,
  output amdfs_pkg::amdfs_stat_t                stat
);
  import amdfs_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int DW     = $clog2(MAX_VERTICES + 1);
  localparam int MW     = MAX_VERTICES;

  amdfs_state_t      state_r, state_nxt;
  logic [VIDX_W-1:0] ea_r, ea_nxt;
  logic [VIDX_W-1:0] eb_r, eb_nxt;
  logic [MW-1:0]     visited_r, visited_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [VIDX_W-1:0] top_r, top_nxt;
  logic [MW-1:0]     cand_r, cand_nxt;
  logic [VIDX_W-1:0] hold_r, hold_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VW-1:0]     out_v_r, out_v_nxt;
  logic              out_last_r, out_last_nxt;

  logic [VW-1:0]     in_a;
  logic [VW-1:0]     in_b;
  logic              a_ok;
  logic              b_ok;
  logic              slot_free;
  logic [MW-1:0]     colmask;
  logic [VIDX_W-1:0] pick;
  logic [DW-1:0]     depth_m2;

  assign in_a      = in_tdata[VW-1:0];
  assign in_b      = in_tdata[2*VW-1:VW];
  assign a_ok      = ({1'b0, in_a} < n_eff);
  assign b_ok      = ({1'b0, in_b} < n_eff);
  assign slot_free = !out_valid_r || out_tready;
  assign depth_m2  = depth_r - DW'(2);

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      colmask[i] = (VCNT_W'(i) < n_eff);
    end
  end

  // lowest set candidate
  always_comb begin
    pick = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (cand_r[i]) begin
        pick = VIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    visited_r  <= visited_nxt;
    top_r      <= top_nxt;
    cand_r     <= cand_nxt;
    hold_r     <= hold_nxt;
    out_v_r    <= out_v_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    visited_nxt   = visited_r;
    depth_nxt     = depth_r;
    top_nxt       = top_r;
    cand_nxt      = cand_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_v_nxt     = out_v_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    adj_ctl       = '0;
    adj_waddr     = ea_r;
    adj_wdata     = adj_rdata;
    adj_raddr     = top_r;
    stk_ctl       = '0;
    stk_waddr     = depth_r[VIDX_W-1:0];
    stk_wdata     = pick;
    stk_raddr     = depth_m2[VIDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ea_nxt = in_a[VIDX_W-1:0];
          eb_nxt = in_b[VIDX_W-1:0];
          if (in_tuser == FUNC_EDGE) begin
            if (a_ok && b_ok) begin
              adj_ctl.rd_en = 1'b1;
              adj_raddr     = in_a[VIDX_W-1:0];
              state_nxt     = S_EA_WR;
            end
          end else begin
            visited_nxt = '0;
            if (a_ok) begin
              visited_nxt   = MW'(1) << in_a[VIDX_W-1:0];
              hold_nxt      = in_a[VIDX_W-1:0];
              top_nxt       = in_a[VIDX_W-1:0];
              stk_ctl.wr_en = 1'b1;
              stk_waddr     = '0;
              stk_wdata     = in_a[VIDX_W-1:0];
              depth_nxt     = DW'(1);
              adj_ctl.rd_en = 1'b1;
              adj_raddr     = in_a[VIDX_W-1:0];
              state_nxt     = S_SCAN;
            end
          end
        end
      end
      S_EA_WR: begin
        adj_ctl.wr_en = 1'b1;
        adj_waddr     = ea_r;
        adj_wdata     = adj_rdata | (MW'(1) << eb_r);
        adj_ctl.rd_en = 1'b1;
        adj_raddr     = eb_r;
        state_nxt     = S_EB_WR;
      end
      S_EB_WR: begin
        adj_ctl.wr_en = 1'b1;
        adj_waddr     = eb_r;
        adj_wdata     = adj_rdata | (MW'(1) << ea_r);
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        cand_nxt  = adj_rdata & ~visited_r & colmask & ~(MW'(1) << top_r);
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (cand_r != '0) begin
          if (slot_free) begin
            out_valid_nxt        = 1'b1;
            out_v_nxt            = VW'(hold_r);
            out_last_nxt         = 1'b0;
            hold_nxt             = pick;
            visited_nxt[pick]    = 1'b1;
            stk_ctl.wr_en        = 1'b1;
            stk_waddr            = depth_r[VIDX_W-1:0];
            stk_wdata            = pick;
            depth_nxt            = depth_r + DW'(1);
            top_nxt              = pick;
            adj_ctl.rd_en        = 1'b1;
            adj_raddr            = pick;
            state_nxt            = S_SCAN;
          end
        end else if (depth_r == DW'(1)) begin
          depth_nxt = '0;
          state_nxt = S_FLUSH;
        end else begin
          depth_nxt     = depth_r - DW'(1);
          stk_ctl.rd_en = 1'b1;
          stk_raddr     = depth_m2[VIDX_W-1:0];
          state_nxt     = S_POPRD;
        end
      end
      S_POPRD: begin
        top_nxt       = stk_rdata;
        adj_ctl.rd_en = 1'b1;
        adj_raddr     = stk_rdata;
        state_nxt     = S_SCAN;
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_v_nxt     = VW'(hold_r);
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid       = out_valid_r;
  assign out_tdata        = OUT_TDATA_W'(out_v_r);
  assign out_tlast        = out_last_r;
  assign stat.idle        = (state_r == S_IDLE);
  assign stat.stack_empty = (depth_r == '0);

endmodule

// ===== src/adjacency_matrix_dfs_order_unit.sv =====
// depth-first preorder walk over an adjacency bit matrix, top level
//
// in_* channel: one beat per item. tuser selects edge load or start of a walk;
// tdata carries the two vertex indexes. An edge beat sets both symmetric bits
// of the matrix, reading and rewriting each row; an edge with an endpoint at
// or above the vertex count, or a start vertex out of range, is dropped.
// A start beat clears the visited set and walks from the given vertex; each
// newly reached vertex leaves on out_* in preorder, the final one with tlast.
// Every step of the walk reads one adjacency row from the registered row
// memory: a descent goes through S_PICK and S_SCAN, a return reads the stack
// memory from S_PICK, then goes through S_POPRD and S_SCAN.
// Each result leaves only after its successor is found or the walk ends,
// since tlast is known only then.
// One item is worked on at a time; in_tready is high only between items.
// cfg_* sets the vertex count, to be written only while the unit is idle.
// out_tvalid holds with stable data while out_tready is low, and the walk
// stalls until the output register is free.
// Reset clears the matrix through per-row valid bits, the stack depth and the
// output register, and sets the vertex count to its maximum; no sweep needed.
`include "adjacency_matrix_dfs_order_unit_defines.svh"

module adjacency_matrix_dfs_order_unit #(
  parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [amdfs_pkg::IN_TDATA_W-1:0]   in_tdata,   // vertex_a, vertex_b, zero pad
  input  logic                               in_tuser,   // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [amdfs_pkg::OUT_TDATA_W-1:0]  out_tdata,  // visited_vertex, zero pad
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [amdfs_pkg::VCNT_W-1:0]       cfg_data
);
  import amdfs_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);

  logic [VCNT_W-1:0]       vertex_count_r;
  logic [VCNT_W-1:0]       n_eff;
  mem_ctl_t                adj_ctl;
  logic [VIDX_W-1:0]       adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [VIDX_W-1:0]       adj_raddr;
  logic [MAX_VERTICES-1:0] adj_rdata;
  mem_ctl_t                stk_ctl;
  logic [VIDX_W-1:0]       stk_waddr;
  logic [VIDX_W-1:0]       stk_wdata;
  logic [VIDX_W-1:0]       stk_raddr;
  logic [VIDX_W-1:0]       stk_rdata;
  amdfs_stat_t             stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCNT_W'(MAX_VERTICES_DEF);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count_r <= cfg_data;
    end
  end

  assign n_eff = (vertex_count_r > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                          : vertex_count_r;

  amdfs_adj_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (adj_ctl),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  amdfs_stack_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_stack_mem (
    .clk   (clk),
    .ctl   (stk_ctl),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  amdfs_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_eff      (n_eff),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .adj_ctl    (adj_ctl),
    .adj_waddr  (adj_waddr),
    .adj_wdata  (adj_wdata),
    .adj_raddr  (adj_raddr),
    .adj_rdata  (adj_rdata),
    .stk_ctl    (stk_ctl),
    .stk_waddr  (stk_waddr),
    .stk_wdata  (stk_wdata),
    .stk_raddr  (stk_raddr),
    .stk_rdata  (stk_rdata),
    .stat       (stat)
  );

  // only the final beat of a walk may still wait while a new item is taken
  `AMDFS_ASSERT(a_idle_only_last, clk, rst_n, (in_tready && out_tvalid) |-> out_tlast, "non-last beat pending while idle")
  `AMDFS_ASSERT(a_idle_stack_empty, clk, rst_n, stat.idle |-> stat.stack_empty, "stack not empty while idle")
  `AMDFS_ASSERT_NEXT(a_start_pushes, clk, rst_n, in_tvalid && in_tready && (in_tuser == FUNC_START) && ({1'b0, in_tdata[VW-1:0]} < n_eff), !stat.stack_empty, "valid start did not push")

endmodule

// ===== verif/tb_adjacency_matrix_dfs_order_unit.sv =====
// self-checking testbench for the adjacency matrix depth-first order unit
module tb_adjacency_matrix_dfs_order_unit;
  import amdfs_pkg::*;

  localparam int NV             = 64;
  localparam int DRAIN_CYCLES   = 5 * NV + 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 300;
  localparam int SCRIPT_ROWS    = 25;

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic          last;
  } visit_t;

  typedef enum logic [1:0] {ROW_EDGE, ROW_START, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_ALONE} row_chk_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [VCNT_W-1:0] a;
    logic [VW-1:0]     b;
    row_chk_t          chk;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [VCNT_W-1:0]      cfg_data = '0;

  // predictor state
  logic [NV-1:0]     adj_rows [NV];
  logic [NV-1:0]     seen;
  logic [VW-1:0]     stk_vtx [NV];
  logic [VCNT_W-1:0] stk_next [NV];
  int                depth;
  logic [VCNT_W-1:0] vcount;

  visit_t walk_out [$];
  visit_t visit_q [$];

  int errors = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int ready_tick = 0;
  int ready_mode = 0;

  script_row_t script [SCRIPT_ROWS] = '{
    '{ROW_START, 7'd0,   6'd0,  CHK_ALONE},
    '{ROW_START, 7'd63,  6'd0,  CHK_ALONE},
    '{ROW_EDGE,  7'd0,   6'd63, CHK_MODEL},
    '{ROW_EDGE,  7'd5,   6'd5,  CHK_MODEL},
    '{ROW_START, 7'd5,   6'd63, CHK_ALONE},
    '{ROW_START, 7'd0,   6'd0,  CHK_MODEL},
    '{ROW_EDGE,  7'd1,   6'd2,  CHK_MODEL},
    '{ROW_EDGE,  7'd2,   6'd3,  CHK_MODEL},
    '{ROW_EDGE,  7'd0,   6'd1,  CHK_MODEL},
    '{ROW_EDGE,  7'd63,  6'd63, CHK_MODEL},
    '{ROW_START, 7'd2,   6'd0,  CHK_MODEL},
    '{ROW_START, 7'd63,  6'd0,  CHK_MODEL},
    '{ROW_CFG,   7'd1,   6'd0,  CHK_MODEL},
    '{ROW_START, 7'd0,   6'd0,  CHK_ALONE},
    '{ROW_EDGE,  7'd0,   6'd1,  CHK_MODEL},
    '{ROW_START, 7'd1,   6'd0,  CHK_SILENT},
    '{ROW_CFG,   7'd0,   6'd0,  CHK_MODEL},
    '{ROW_START, 7'd0,   6'd0,  CHK_SILENT},
    '{ROW_CFG,   7'd127, 6'd0,  CHK_MODEL},
    '{ROW_EDGE,  7'd62,  6'd63, CHK_MODEL},
    '{ROW_START, 7'd63,  6'd0,  CHK_MODEL},
    '{ROW_CFG,   7'd3,   6'd0,  CHK_MODEL},
    '{ROW_START, 7'd2,   6'd0,  CHK_MODEL},
    '{ROW_START, 7'd62,  6'd0,  CHK_SILENT},
    '{ROW_CFG,   7'd64,  6'd0,  CHK_MODEL}
  };

  adjacency_matrix_dfs_order_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (errors < 40) $display("mismatch: %s", what);
    errors++;
  endtask

  // fills walk_out with the preorder visits caused by one item, and updates adj_rows for an edge
  task automatic predict_dfs_item(input logic func, input logic [VW-1:0] a,
                                  input logic [VW-1:0] b);
    int     n;
    int     top;
    int     i;
    logic   [VW-1:0] v;
    bit     pushed;
    visit_t tail;
    walk_out.delete();
    n = (vcount > 7'd64) ? NV : int'(vcount);
    if (func == FUNC_EDGE) begin
      if (a < n && b < n) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      return;
    end
    seen = '0;
    depth = 0;
    if (a >= n) return;
    seen[a] = 1'b1;
    walk_out.push_back('{vtx: a, last: 1'b0});
    stk_vtx[0] = a;
    stk_next[0] = '0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      v = stk_vtx[top];
      pushed = 1'b0;
      for (i = int'(stk_next[top]); i < n && !pushed; i++) begin
        if (i != v && adj_rows[v][i] && !seen[i]) begin
          stk_next[top] = VCNT_W'(i + 1);
          seen[i] = 1'b1;
          walk_out.push_back('{vtx: VW'(i), last: 1'b0});
          stk_vtx[depth] = VW'(i);
          stk_next[depth] = '0;
          depth++;
          pushed = 1'b1;
        end
      end
      if (!pushed) begin
        stk_next[top] = VCNT_W'(n);
        depth--;
      end
    end
    tail = walk_out.pop_back();
    tail.last = 1'b1;
    walk_out.push_back(tail);
  endtask

  task automatic send_item(input logic func, input logic [VW-1:0] a,
                           input logic [VW-1:0] b, input row_chk_t chk);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, b, a};
    in_tuser <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_dfs_item(func, a, b);
    case (chk)
      CHK_ALONE: visit_q.push_back('{vtx: a, last: 1'b1});
      CHK_SILENT: ;
      default: foreach (walk_out[k]) visit_q.push_back(walk_out[k]);
    endcase
  endtask

  // drop the input, wait for every visit and for the walk to wind down
  task automatic drain;
    @(negedge clk) in_tvalid <= 1'b0;
    while (visit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [VCNT_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vcount = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // receiver stall pattern, switching at random among four styles
  always @(negedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 300 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 2) != 0);
      2: out_tready <= (ready_tick % 7 < 4);
      default: out_tready <= (ready_tick % 64 < 40);
    endcase
  end

  always @(posedge clk) begin
    visit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (visit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat vertex %0d last %0b",
                                  out_tdata[VW-1:0], out_tlast));
      end else begin
        want = visit_q.pop_front();
        if (out_tdata[VW-1:0] !== want.vtx)
          report_mismatch($sformatf("visited_vertex %0d, expected %0d",
                                    out_tdata[VW-1:0], want.vtx));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last_vertex %0b, expected %0b at vertex %0d",
                                    out_tlast, want.last, want.vtx));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int       sent;
    int       phase_len;
    int       n;
    int       r;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    foreach (adj_rows[k]) adj_rows[k] = '0;
    seen = '0;
    depth = 0;
    vcount = 7'd64;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) begin
      if (script[k].kind == ROW_CFG)
        set_vertex_count(script[k].a);
      else
        send_item(script[k].kind == ROW_START ? FUNC_START : FUNC_EDGE,
                  script[k].a[VW-1:0], script[k].b, script[k].chk);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: set_vertex_count(7'd64);
        1: set_vertex_count(7'd127);
        2: set_vertex_count(VCNT_W'($urandom_range(1, 64)));
        3: set_vertex_count(VCNT_W'($urandom_range(2, 16)));
        4: set_vertex_count(VCNT_W'($urandom_range(65, 127)));
        default: set_vertex_count(VCNT_W'($urandom_range(0, 1)));
      endcase
      n = (vcount > 7'd64) ? NV : int'(vcount);
      phase_len = $urandom_range(15, 40);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        a = VW'($urandom_range(0, 63));
        b = VW'($urandom_range(0, 63));
        if (n > 0 && (r < 70 || (r >= 80 && r < 95))) begin
          a = VW'($urandom_range(0, n - 1));
          b = ($urandom_range(0, 9) == 0) ? a : VW'($urandom_range(0, n - 1));
        end
        send_item((r < 80) ? FUNC_EDGE : FUNC_START, a, b, CHK_MODEL);
        sent++;
      end
    end

    drain();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
